### hdl/grid_line_of_sight_check_assert.svh
// Assertion macros shared by the line-of-sight checker
`ifndef GRID_LINE_OF_SIGHT_CHECK_ASSERT_SVH
`define GRID_LINE_OF_SIGHT_CHECK_ASSERT_SVH

// Check a condition in the same cycle as its trigger
`define GLOS_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a condition in the cycle after its trigger
`define GLOS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/glos_pkg.sv
// Shared constants, command and status types for the line-of-sight block
`timescale 1ns / 1ps

package glos_pkg;

    // Sizing of the march and the map
    localparam int SAMPLE_COUNT    = 64;
    localparam int TILE_SIZE       = 64;
    localparam int MAP_MAX_COLUMNS = 64;
    localparam int MAP_MAX_ROWS    = 64;

    // Field widths
    localparam int IN_POS_W   = 24;
    localparam int CELL_W     = 6;
    localparam int CFG_W      = 7;
    localparam int FRAC_EXTRA = 6;
    localparam int IN_FRAC    = 8;

    // Internal position format: input with extra fraction bits
    localparam int POS_W        = IN_POS_W + FRAC_EXTRA;
    localparam int DIFF_W       = POS_W + 1;
    localparam int SAMPLE_SHIFT = $clog2(SAMPLE_COUNT);
    localparam int IDX_W        = (SAMPLE_SHIFT > 0) ? SAMPLE_SHIFT : 1;
    localparam int TILE_SHIFT   = $clog2(TILE_SIZE) + IN_FRAC + FRAC_EXTRA;
    localparam int COORD_W      = POS_W - TILE_SHIFT;

    // Map storage
    localparam int MAP_DEPTH  = MAP_MAX_COLUMNS * MAP_MAX_ROWS;
    localparam int MAP_ADDR_W = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;
    localparam int MAP_ROW_W  = (MAP_MAX_ROWS > 1) ? $clog2(MAP_MAX_ROWS) : 1;
    localparam int MAP_COL_W  = (MAP_MAX_COLUMNS > 1) ? $clog2(MAP_MAX_COLUMNS) : 1;
    localparam int LIM_W      = 9;
    localparam int CMP_W      = (COORD_W > LIM_W) ? COORD_W : LIM_W;

    // Register indexes of the configuration port
    localparam logic CFG_MAP_WIDTH  = 1'b0;
    localparam logic CFG_MAP_HEIGHT = 1'b1;

    // Operation codes
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // Controller to datapath commands
    typedef struct packed {
        logic clear_step;
        logic write_cell;
        logic load_query;
        logic prep_step;
        logic sample;
        logic load_result;
    } glos_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic clear_last;
        logic sample_last;
    } glos_status_t;

endpackage

### hdl/grid_line_of_sight_check.sv
// Top level of the grid line-of-sight checker
`timescale 1ns / 1ps
//
// Keeps a blocked-cell map and answers line-of-sight queries over it.
// Item channel (item_valid/item_ready): operation 0 writes one map cell
// (cell_column, cell_row, cell_blocked) in the cycle it is accepted and gives
// no result; operation 1 marches SAMPLE_COUNT points from start toward end.
// Result channel (result_valid/result_ready): one sight_blocked per query.
// Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data): map width at
// index 0 and map height at index 1; cfg_ready is always high.
// A query reads one map cell per sample through the single map port, and
// the item channel stays closed through PREP, RUN, DRAIN and DONE until the
// result is loaded and result_valid rises; a write keeps the channel open.
// After reset the map is cleared one cell per cycle, over all MAP_DEPTH
// cells (4096), with item_ready low; config writes are taken meanwhile.
// A waiting result does not block writes or a new query; a finished query
// holds in its last step until the result register is free.
//
module grid_line_of_sight_check (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          item_valid,
    output logic                          item_ready,
    input  logic                          operation,
    input  logic [glos_pkg::CELL_W-1:0]   cell_column,
    input  logic [glos_pkg::CELL_W-1:0]   cell_row,
    input  logic                          cell_blocked,
    input  logic [glos_pkg::IN_POS_W-1:0] start_x,
    input  logic [glos_pkg::IN_POS_W-1:0] start_y,
    input  logic [glos_pkg::IN_POS_W-1:0] end_x,
    input  logic [glos_pkg::IN_POS_W-1:0] end_y,
    output logic                          result_valid,
    input  logic                          result_ready,
    output logic                          sight_blocked,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic                          cfg_index,
    input  logic [glos_pkg::CFG_W-1:0]    cfg_data
);

    import glos_pkg::*;

    glos_cmd_t    cmd;
    glos_status_t status;

    // Config registers take every write
    assign cfg_ready = 1'b1;

    glos_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item_ready  (item_ready),
        .operation   (operation),
        .result_valid(result_valid),
        .result_ready(result_ready),
        .cmd         (cmd),
        .status      (status)
    );

    glos_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .cfg_valid    (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cell_column  (cell_column),
        .cell_row     (cell_row),
        .cell_blocked (cell_blocked),
        .start_x      (start_x),
        .start_y      (start_y),
        .end_x        (end_x),
        .end_y        (end_y),
        .sight_blocked(sight_blocked)
    );

endmodule

### hdl/glos_ram.sv
// Generic single-port RAM with registered read data
`timescale 1ns / 1ps

module glos_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Read first port: a write cycle returns the old contents
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[addr] <= wdata;
        end
        rdata_reg <= mem_reg[addr];
    end

    assign rdata = rdata_reg;

endmodule

### hdl/glos_datapath.sv
// Datapath: map memory, config registers, ray march position and result
`timescale 1ns / 1ps

module glos_datapath (
    input  logic                         clk,
    input  logic                         rst_n,
    input  glos_pkg::glos_cmd_t          cmd,
    output glos_pkg::glos_status_t       status,
    input  logic                         cfg_valid,
    input  logic                         cfg_index,
    input  logic [glos_pkg::CFG_W-1:0]   cfg_data,
    input  logic [glos_pkg::CELL_W-1:0]  cell_column,
    input  logic [glos_pkg::CELL_W-1:0]  cell_row,
    input  logic                         cell_blocked,
    input  logic [glos_pkg::IN_POS_W-1:0] start_x,
    input  logic [glos_pkg::IN_POS_W-1:0] start_y,
    input  logic [glos_pkg::IN_POS_W-1:0] end_x,
    input  logic [glos_pkg::IN_POS_W-1:0] end_y,
    output logic                         sight_blocked
);

    import glos_pkg::*;

    logic [CFG_W-1:0]        map_width_reg;
    logic [CFG_W-1:0]        map_height_reg;
    logic [MAP_ADDR_W-1:0]   clr_addr_reg;
    logic [POS_W-1:0]        px_reg, px_next;
    logic [POS_W-1:0]        py_reg, py_next;
    logic signed [DIFF_W-1:0] dx_reg, dy_reg;
    logic signed [DIFF_W-1:0] step_x_reg, step_y_reg;
    logic signed [DIFF_W-1:0] step_x_next, step_y_next;
    logic signed [IN_POS_W:0] diff_x, diff_y;
    logic [IDX_W-1:0]        idx_reg;
    logic                    hit_pend_reg;
    logic                    acc_reg;
    logic                    result_reg;
    logic [LIM_W-1:0]        eff_w, eff_h;
    logic [COORD_W-1:0]      col, row;
    logic                    in_map;
    logic [MAP_ADDR_W-1:0]   sample_addr, write_addr;
    logic                    write_ok;
    logic                    ram_we;
    logic [MAP_ADDR_W-1:0]   ram_addr;
    logic [0:0]              ram_wdata, ram_rdata;

    // Clip the configured map size to the storage size
    always_comb
    begin
        eff_w = (LIM_W'(map_width_reg) < LIM_W'(MAP_MAX_COLUMNS)) ?
                LIM_W'(map_width_reg) : LIM_W'(MAP_MAX_COLUMNS);
        eff_h = (LIM_W'(map_height_reg) < LIM_W'(MAP_MAX_ROWS)) ?
                LIM_W'(map_height_reg) : LIM_W'(MAP_MAX_ROWS);
    end

    // Map the current sample position to a cell
    always_comb
    begin
        col         = px_reg[POS_W-1:TILE_SHIFT];
        row         = py_reg[POS_W-1:TILE_SHIFT];
        in_map      = (CMP_W'(col) < CMP_W'(eff_w)) && (CMP_W'(row) < CMP_W'(eff_h));
        sample_addr = MAP_ADDR_W'(32'(row[MAP_ROW_W-1:0]) * MAP_MAX_COLUMNS
                                  + 32'(col[MAP_COL_W-1:0]));
    end

    // Decode the cell write address and drop writes beyond storage
    always_comb
    begin
        write_ok   = (LIM_W'(cell_column) < LIM_W'(MAP_MAX_COLUMNS)) &&
                     (LIM_W'(cell_row) < LIM_W'(MAP_MAX_ROWS));
        write_addr = MAP_ADDR_W'(32'(cell_row) * MAP_MAX_COLUMNS + 32'(cell_column));
    end

    // Share the single map port between clearing, cell writes and sampling
    always_comb
    begin
        ram_we    = 1'b0;
        ram_addr  = sample_addr;
        ram_wdata = 1'b0;
        if (cmd.clear_step)
        begin
            ram_we   = 1'b1;
            ram_addr = clr_addr_reg;
        end
        else if (cmd.write_cell)
        begin
            ram_we    = write_ok;
            ram_addr  = write_addr;
            ram_wdata = cell_blocked;
        end
    end

    glos_ram #(
        .WIDTH(1),
        .DEPTH(MAP_DEPTH)
    ) u_map (
        .clk  (clk),
        .we   (ram_we),
        .addr (ram_addr),
        .wdata(ram_wdata),
        .rdata(ram_rdata)
    );

    // Span of the segment, signed
    always_comb
    begin
        diff_x = $signed({1'b0, end_x}) - $signed({1'b0, start_x});
        diff_y = $signed({1'b0, end_y}) - $signed({1'b0, start_y});
    end

    // Divide the span by the sample count, truncating toward zero
    always_comb
    begin
        step_x_next = $signed(dx_reg + (dx_reg[DIFF_W-1] ? DIFF_W'(SAMPLE_COUNT - 1) : '0))
                      >>> SAMPLE_SHIFT;
        step_y_next = $signed(dy_reg + (dy_reg[DIFF_W-1] ? DIFF_W'(SAMPLE_COUNT - 1) : '0))
                      >>> SAMPLE_SHIFT;
    end

    // Advance to the next sample; every sample stays between start and end
    always_comb
    begin
        px_next = POS_W'($signed({1'b0, px_reg}) + step_x_reg);
        py_next = POS_W'($signed({1'b0, py_reg}) + step_y_reg);
    end

    // Query payload: position, span and step, and the result register
    always_ff @(posedge clk)
    begin
        if (cmd.load_query)
        begin
            px_reg <= {start_x, FRAC_EXTRA'(0)};
            py_reg <= {start_y, FRAC_EXTRA'(0)};
            dx_reg <= {diff_x, FRAC_EXTRA'(0)};
            dy_reg <= {diff_y, FRAC_EXTRA'(0)};
        end
        else if (cmd.sample)
        begin
            px_reg <= px_next;
            py_reg <= py_next;
        end
        if (cmd.prep_step)
        begin
            step_x_reg <= step_x_next;
            step_y_reg <= step_y_next;
        end
        if (cmd.load_result)
        begin
            result_reg <= acc_reg;
        end
    end

    // Config registers, clear sweep, sample count and hit accumulation
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_width_reg  <= CFG_W'(MAP_MAX_COLUMNS);
            map_height_reg <= CFG_W'(MAP_MAX_ROWS);
            clr_addr_reg   <= '0;
            idx_reg        <= '0;
            hit_pend_reg   <= 1'b0;
            acc_reg        <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    CFG_MAP_WIDTH:  map_width_reg  <= cfg_data;
                    CFG_MAP_HEIGHT: map_height_reg <= cfg_data;
                    default:        map_width_reg  <= map_width_reg;
                endcase
            end
            if (cmd.clear_step)
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
            if (cmd.load_query)
            begin
                idx_reg <= '0;
            end
            else if (cmd.sample)
            begin
                idx_reg <= idx_reg + 1'b1;
            end
            hit_pend_reg <= cmd.sample & in_map;
            if (cmd.load_query)
            begin
                acc_reg <= 1'b0;
            end
            else
            begin
                acc_reg <= acc_reg | (hit_pend_reg & ram_rdata[0]);
            end
        end
    end

    assign status.clear_last  = (clr_addr_reg == MAP_ADDR_W'(MAP_DEPTH - 1));
    assign status.sample_last = (idx_reg == IDX_W'(SAMPLE_COUNT - 1));
    assign sight_blocked      = result_reg;

endmodule

### hdl/glos_ctrl.sv
// Controller: clear sweep, item handshake, march sequencing and result slot
`timescale 1ns / 1ps

module glos_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   item_valid,
    output logic                   item_ready,
    input  logic                   operation,
    output logic                   result_valid,
    input  logic                   result_ready,
    output glos_pkg::glos_cmd_t    cmd,
    input  glos_pkg::glos_status_t status
);

    import glos_pkg::*;

    typedef enum logic [5:0] {
        ST_CLEAR = 6'b000001,
        ST_IDLE  = 6'b000010,
        ST_PREP  = 6'b000100,
        ST_RUN   = 6'b001000,
        ST_DRAIN = 6'b010000,
        ST_DONE  = 6'b100000
    } glos_state_t;

    glos_state_t state_reg, state_next;
    logic        result_valid_reg, result_valid_next;
    logic        item_fire;
    logic        slot_free;

    assign item_ready = (state_reg == ST_IDLE);
    assign item_fire  = item_valid & item_ready;
    assign slot_free  = ~result_valid_reg | result_ready;

    // Sequence the clear sweep, cell writes and each query
    always_comb
    begin
        state_next        = state_reg;
        result_valid_next = result_valid_reg & ~result_ready;
        cmd               = '0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (status.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (item_fire)
                begin
                    if (operation == OP_QUERY)
                    begin
                        cmd.load_query = 1'b1;
                        state_next     = ST_PREP;
                    end
                    else
                    begin
                        cmd.write_cell = 1'b1;
                    end
                end
            end
            ST_PREP:
            begin
                cmd.prep_step = 1'b1;
                state_next    = ST_RUN;
            end
            ST_RUN:
            begin
                cmd.sample = 1'b1;
                if (status.sample_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                // Hold until the result slot is free
                if (slot_free)
                begin
                    cmd.load_result   = 1'b1;
                    result_valid_next = 1'b1;
                    state_next        = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_CLEAR;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            result_valid_reg <= result_valid_next;
        end
    end

    assign result_valid = result_valid_reg;

endmodule

### hdl/glos_checker.sv
// Port-level checker for the line-of-sight block and its bind
`timescale 1ns / 1ps
`include "grid_line_of_sight_check_assert.svh"

module glos_checker (
    input logic clk,
    input logic rst_n,
    input logic item_valid,
    input logic item_ready,
    input logic operation,
    input logic result_valid,
    input logic result_ready,
    input logic sight_blocked
);

    import glos_pkg::*;

    // A stalled result holds its value
    `GLOS_ASSERT_NEXT(a_result_hold, result_valid && !result_ready, result_valid && $stable(sight_blocked), "result dropped or changed while stalled")

    // A query transaction closes the item channel while it marches
    `GLOS_ASSERT_NEXT(a_query_busy, item_valid && item_ready && operation == OP_QUERY, !item_ready, "item accepted during a query")

    // A cell write never produces a result
    `GLOS_ASSERT_NEXT(a_write_silent, item_valid && item_ready && operation == OP_WRITE && !result_valid, !result_valid, "result after a cell write")

    // A new result appears only as a query finishes and the channel reopens
    `GLOS_ASSERT_SAME(a_result_at_done, $rose(result_valid), $rose(item_ready), "result outside query completion")

endmodule

bind grid_line_of_sight_check glos_checker u_glos_checker (.*);
